// ----- rtl/mxt_pkg.sv -----
// Shared types and constants for the maximum-xor binary trie.
// No dependencies; imported by mxt_step, the trie core and the bench.
package mxt_pkg;

  localparam int KEY_BITS   = 31;
  localparam int POOL_NODES = 32768;
  localparam int NODE_W     = $clog2(POOL_NODES);
  localparam int CNT_W      = 16;
  localparam int FREE_W     = NODE_W + 1;
  localparam int BIT_W      = $clog2(KEY_BITS);
  localparam int MISS_W     = $clog2(KEY_BITS + 1);

  localparam logic [CNT_W-1:0]  CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [FREE_W-1:0] POOL_LAST = FREE_W'(POOL_NODES - 1);
  localparam logic [NODE_W-1:0] NO_NODE   = '0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_QUERY  = 2'd3
  } op_t;

  // Counts of each child live in the parent entry, so one read per level
  // gives everything a step needs.
  typedef struct packed {
    logic [NODE_W-1:0] child0;
    logic [NODE_W-1:0] child1;
    logic [CNT_W-1:0]  cnt0;
    logic [CNT_W-1:0]  cnt1;
  } node_t;

  localparam int ENTRY_W = $bits(node_t);

  typedef struct packed {
    op_t               op;
    logic              key_bit;
    logic              upd;
    logic [NODE_W-1:0] alloc_idx;
  } step_ctl_t;

  typedef struct packed {
    logic [NODE_W-1:0] next_node;
    logic              hit_null;
    logic              cnt_zero;
    logic              take_opp;
    logic              new_node;
    node_t             wr_entry;
  } step_res_t;

endpackage

// ----- rtl/mxt_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mxt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/mxt_step.sv -----
// One trie level: picks the next node and builds the updated parent entry.
// Depends on mxt_pkg.
module mxt_step
  import mxt_pkg::*;
(
  input  node_t     entry,
  input  step_ctl_t ctl,
  output step_res_t res
);

  logic [NODE_W-1:0] child;
  logic [NODE_W-1:0] opp;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  opp_cnt;
  logic [CNT_W-1:0]  new_cnt;

  always_comb begin
    child   = ctl.key_bit ? entry.child1 : entry.child0;
    opp     = ctl.key_bit ? entry.child0 : entry.child1;
    cnt     = ctl.key_bit ? entry.cnt1 : entry.cnt0;
    opp_cnt = ctl.key_bit ? entry.cnt0 : entry.cnt1;

    res          = '0;
    res.hit_null = (child == NO_NODE);
    res.cnt_zero = (cnt == '0);
    res.take_opp = (ctl.op == OP_QUERY) && (opp != NO_NODE) && (opp_cnt != '0);
    res.new_node = ctl.upd && (ctl.op == OP_INSERT) && (child == NO_NODE);

    if (res.take_opp) begin
      res.next_node = opp;
    end else if (res.new_node) begin
      res.next_node = ctl.alloc_idx;
    end else begin
      res.next_node = child;
    end

    // saturating count update; a fresh child's count starts at one
    if (res.new_node) begin
      new_cnt = CNT_W'(1);
    end else if (ctl.op == OP_INSERT) begin
      new_cnt = (cnt == CNT_MAX) ? cnt : cnt + CNT_W'(1);
    end else begin
      new_cnt = (cnt == '0) ? cnt : cnt - CNT_W'(1);
    end

    res.wr_entry = entry;
    if (ctl.key_bit) begin
      res.wr_entry.child1 = res.next_node;
      res.wr_entry.cnt1   = new_cnt;
    end else begin
      res.wr_entry.child0 = res.next_node;
      res.wr_entry.cnt0   = new_cnt;
    end
  end

endmodule

// ----- rtl/max_xor_binary_trie_core.sv -----
// Maximum-xor binary trie over 31-bit keys, node pool in one RAM.
//
// Input channel (in_valid / in_stall): operation and key. A word is taken
// when in_valid is high and in_stall low; in_stall is low only while the
// block is idle and out of reset, so it works on one word at a time.
// Output channel (out_valid / out_stall): max_xor and status, one word per
// input word, in order. The result sits in an output register; a stalled
// result holds, and the next word runs up to its result and waits there
// with in_stall high.
// Steps per word: clear goes straight to its result; query reads one node
// per key bit, ending early when the walk leaves the trie; remove makes a
// read-only pass, then an update pass only if the key is present; insert
// makes a read-only pass checking free nodes, then an update pass.
// out_valid rises as the block goes back to idle, ready for the next word.
// Each level costs one cycle: the RAM read of a node feeds the address of
// the next read through the step logic.
// Reset (rst, synchronous) gives an empty trie with only the root; the root
// entry lives in registers, so no RAM clearing pass is needed. Only clear
// and reset free nodes; an insert needing more than remain returns status 1.
module max_xor_binary_trie_core
  import mxt_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          operation,
  input  logic [KEY_BITS-1:0] key,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [KEY_BITS-1:0] max_xor,
  output logic                status
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t              state;
  op_t                 op;
  logic [KEY_BITS-1:0] key_r;
  logic [BIT_W-1:0]    bit_idx;
  logic [NODE_W-1:0]   node;
  logic                at_root;
  logic                cur_new;
  logic                upd_pass;
  logic [KEY_BITS-1:0] best;
  logic                status_r;
  logic [FREE_W-1:0]   next_free;
  node_t               root_entry;

  node_t               cur_entry;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic                ram_we;
  step_ctl_t           ctl;
  step_res_t           res;
  logic [MISS_W-1:0]   missing;
  logic                pool_short;
  logic                last_bit;

  assign in_stall = rst || (state != S_IDLE);

  always_comb begin
    if (at_root) begin
      cur_entry = root_entry;
    end else if (cur_new) begin
      cur_entry = '0;
    end else begin
      cur_entry = node_t'(ram_rdata);
    end
  end

  assign ctl.op        = op;
  assign ctl.key_bit   = key_r[bit_idx];
  assign ctl.upd       = upd_pass;
  assign ctl.alloc_idx = NODE_W'(next_free + FREE_W'(1));

  mxt_step u_step (
    .entry (cur_entry),
    .ctl   (ctl),
    .res   (res)
  );

  assign ram_we = (state == S_WALK) && upd_pass && !at_root;

  mxt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (POOL_NODES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node),
    .wdata (res.wr_entry),
    .raddr (res.next_node),
    .rdata (ram_rdata)
  );

  // levels below the first missing child all need a new node
  assign missing    = res.hit_null ? MISS_W'(bit_idx) + MISS_W'(1) : '0;
  assign pool_short = (next_free + FREE_W'(missing)) > POOL_LAST;
  assign last_bit   = (bit_idx == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      next_free  <= FREE_W'(1);
      root_entry <= '0;
      out_valid  <= 1'b0;
      upd_pass   <= 1'b0;
      at_root    <= 1'b1;
      cur_new    <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op       <= op_t'(operation);
            key_r    <= key;
            best     <= '0;
            status_r <= 1'b0;
            bit_idx  <= BIT_W'(KEY_BITS - 1);
            at_root  <= 1'b1;
            cur_new  <= 1'b0;
            upd_pass <= 1'b0;
            if (op_t'(operation) == OP_CLEAR) begin
              next_free  <= FREE_W'(1);
              root_entry <= '0;
              state      <= S_DONE;
            end else begin
              state <= S_WALK;
            end
          end
        end
        S_WALK: begin
          if (op == OP_QUERY) begin
            best[bit_idx] <= res.take_opp;
            if (last_bit || res.next_node == NO_NODE) begin
              state <= S_DONE;
            end else begin
              bit_idx <= bit_idx - BIT_W'(1);
              node    <= res.next_node;
              at_root <= 1'b0;
            end
          end else if (!upd_pass) begin
            if (res.hit_null || last_bit) begin
              if (op == OP_INSERT && pool_short) begin
                status_r <= 1'b1;
                state    <= S_DONE;
              end else if (op == OP_REMOVE && (res.hit_null || res.cnt_zero)) begin
                state <= S_DONE;
              end else begin
                upd_pass <= 1'b1;
                bit_idx  <= BIT_W'(KEY_BITS - 1);
                at_root  <= 1'b1;
                cur_new  <= 1'b0;
              end
            end else begin
              bit_idx <= bit_idx - BIT_W'(1);
              node    <= res.next_node;
              at_root <= 1'b0;
            end
          end else begin
            if (at_root) begin
              root_entry <= res.wr_entry;
            end
            if (res.new_node) begin
              next_free <= next_free + FREE_W'(1);
            end
            if (last_bit) begin
              state <= S_DONE;
            end else begin
              bit_idx <= bit_idx - BIT_W'(1);
              node    <= res.next_node;
              at_root <= 1'b0;
              cur_new <= res.new_node;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            max_xor   <= best;
            status    <= status_r;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) next_free <= POOL_LAST)
    else $error("node allocation ran past the pool");

  assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_WALK) && upd_pass && (op == OP_INSERT || op == OP_REMOVE))
    else $error("node RAM written outside an update pass");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && status_r |-> (op == OP_INSERT))
    else $error("refusal flagged on a word other than insert");

  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && (best != '0) |-> (op == OP_QUERY))
    else $error("nonzero result on a word other than query");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (operation == OP_CLEAR) |=> (next_free == FREE_W'(1)))
    else $error("clear did not reset the free node index");

endmodule

// ----- tb/max_xor_binary_trie_core_tb.sv -----
// Self-checking bench for max_xor_binary_trie_core: clear, insert, remove and
// max-xor query words, checked against a behavioral trie kept in a scoreboard.
// Depends on rtl/mxt_pkg.sv, rtl/mxt_ram.sv, rtl/mxt_step.sv and rtl/max_xor_binary_trie_core.sv.
module max_xor_binary_trie_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mxt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int TAIL_CYCLES = 80;
  localparam int FILL_WORDS = 48;
  localparam int HOLD_CYCLES = 400;
  localparam logic [KEY_BITS-1:0] ALL_ONES = {KEY_BITS{1'b1}};
  localparam logic [KEY_BITS-1:0] ONE = KEY_BITS'(1);

  typedef struct packed {
    logic [KEY_BITS-1:0] max_xor;
    logic                status;
  } reply_t;

  class xor_trie_scoreboard;
    bit [NODE_W-1:0] kid0 [POOL_NODES];
    bit [NODE_W-1:0] kid1 [POOL_NODES];
    bit [CNT_W-1:0]  occupancy [POOL_NODES];
    int unsigned     last_node;
    reply_t          expected_replies[$];
    int              op_seen [4];
    int              refused;
    int              nonzero_answers;
    int              checked;
    int              mismatches;

    function new();
      empty_trie();
    endfunction

    function void empty_trie();
      last_node = 1;
      kid0[1] = NO_NODE;
      kid1[1] = NO_NODE;
      occupancy[1] = 1;
    endfunction

    function bit [NODE_W-1:0] child_of(bit [NODE_W-1:0] node, bit b);
      if (node == NO_NODE) return NO_NODE;
      return b ? kid1[node] : kid0[node];
    endfunction

    // returns 1 when the pool cannot hold the new path
    function bit insert_key(bit [KEY_BITS-1:0] k);
      bit [NODE_W-1:0] node;
      bit [NODE_W-1:0] fresh;
      int unsigned     missing;
      node = 1;
      missing = 0;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        if (node != NO_NODE) node = child_of(node, k[i]);
        if (node == NO_NODE) missing++;
      end
      if (last_node + missing > POOL_NODES - 1) return 1'b1;
      node = 1;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        fresh = child_of(node, k[i]);
        if (fresh == NO_NODE) begin
          last_node++;
          fresh = NODE_W'(last_node);
          kid0[fresh] = NO_NODE;
          kid1[fresh] = NO_NODE;
          occupancy[fresh] = 0;
          if (k[i]) kid1[node] = fresh;
          else kid0[node] = fresh;
        end
        if (occupancy[fresh] != CNT_MAX) occupancy[fresh]++;
        node = fresh;
      end
      return 1'b0;
    endfunction

    function void remove_key(bit [KEY_BITS-1:0] k);
      bit [NODE_W-1:0] node;
      node = 1;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        node = child_of(node, k[i]);
        if (node == NO_NODE) return;
      end
      if (occupancy[node] == 0) return;
      node = 1;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        node = child_of(node, k[i]);
        if (occupancy[node] != 0) occupancy[node]--;
      end
    endfunction

    function bit [KEY_BITS-1:0] best_xor(bit [KEY_BITS-1:0] k);
      bit [KEY_BITS-1:0] best;
      bit [NODE_W-1:0]   node;
      bit [NODE_W-1:0]   opp;
      best = '0;
      node = 1;
      for (int i = KEY_BITS - 1; i >= 0; i--) begin
        opp = child_of(node, ~k[i]);
        if (opp != NO_NODE && occupancy[opp] != 0) begin
          best[i] = 1'b1;
          node = opp;
        end else begin
          node = child_of(node, k[i]);
        end
      end
      return best;
    endfunction

    function void note_word(op_t op, bit [KEY_BITS-1:0] k);
      reply_t r;
      r = '0;
      op_seen[int'(op)]++;
      case (op)
        OP_CLEAR: empty_trie();
        OP_INSERT: begin
          r.status = insert_key(k);
          if (r.status) refused++;
        end
        OP_REMOVE: remove_key(k);
        default: begin
          r.max_xor = best_xor(k);
          if (r.max_xor != 0) nonzero_answers++;
        end
      endcase
      expected_replies = {expected_replies, r};
    endfunction

    function void report(string what, logic [KEY_BITS-1:0] want, logic [KEY_BITS-1:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s mismatch, expected %h got %h", $time, what, want, got);
    endfunction

    function void check_reply(logic [KEY_BITS-1:0] mx, logic st);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report("unexpected result word, max_xor", '0, mx);
        return;
      end
      want = expected_replies.pop_front();
      checked++;
      if (mx !== want.max_xor) report("max_xor", want.max_xor, mx);
      if (st !== want.status) report("status", KEY_BITS'(want.status), KEY_BITS'(st));
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [1:0]          operation = OP_CLEAR;
  logic [KEY_BITS-1:0] key = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [KEY_BITS-1:0] max_xor;
  logic                status;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  bit hold_req = 1'b0;
  bit hold_taken = 1'b0;
  logic [KEY_BITS-1:0] stored_keys[$];
  xor_trie_scoreboard sb = new();

  max_xor_binary_trie_core DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .operation (operation),
    .key       (key),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .max_xor   (max_xor),
    .status    (status)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stalls, or a long hold-off once asked for
  always @(posedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES - 1;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && !out_stall) sb.check_reply(max_xor, status);
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_word(input op_t op, input logic [KEY_BITS-1:0] k);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    key <= k;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_word(op, k);
  endtask

  // mostly fresh keys, some close to stored ones, some corner values
  function automatic logic [KEY_BITS-1:0] random_key();
    int pick;
    logic [KEY_BITS-1:0] mask;
    pick = $urandom_range(99);
    if (pick < 25 && stored_keys.size() != 0) begin
      mask = (ONE << $urandom_range(KEY_BITS - 1)) - ONE;
      return stored_keys[$urandom_range(stored_keys.size() - 1)] ^
             (KEY_BITS'($urandom()) & mask);
    end
    if (pick < 35) begin
      case ($urandom_range(3))
        0: return '0;
        1: return ALL_ONES;
        2: return ONE << $urandom_range(KEY_BITS - 1);
        default: return ~(ONE << $urandom_range(KEY_BITS - 1));
      endcase
    end
    return KEY_BITS'($urandom());
  endfunction

  task automatic run_random_phase(input int words, input int idle_pct, input int hold_pct);
    int pick;
    int slot;
    logic [KEY_BITS-1:0] k;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    for (int n = 0; n < words; n++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_word(OP_CLEAR, random_key());
        stored_keys.delete();
      end else if (pick < 42) begin
        k = random_key();
        send_word(OP_INSERT, k);
        stored_keys = {stored_keys, k};
      end else if (pick < 65) begin
        if (stored_keys.size() != 0 && $urandom_range(3) != 0) begin
          slot = $urandom_range(stored_keys.size() - 1);
          k = stored_keys[slot];
          stored_keys.delete(slot);
        end else begin
          k = random_key();
        end
        send_word(OP_REMOVE, k);
      end else begin
        send_word(OP_QUERY, random_key());
      end
    end
  endtask

  initial begin
    logic [10:0]         idx;
    logic [10:0]         rev;
    logic [KEY_BITS-1:0] k;
    logic [KEY_BITS-1:0] fill_key;
    bit                  failed;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty trie, extremes, absent and repeated removes,
    // stale nodes after clear
    send_idle_pct = 34;
    stall_pct = 34;
    send_word(OP_QUERY, '0);
    send_word(OP_QUERY, ALL_ONES);
    send_word(OP_REMOVE, 31'h0001_2345);
    send_word(OP_INSERT, '0);
    send_word(OP_INSERT, ALL_ONES);
    send_word(OP_QUERY, '0);
    send_word(OP_QUERY, ALL_ONES);
    send_word(OP_QUERY, 31'h2AAA_AAAA);
    send_word(OP_INSERT, '0);
    send_word(OP_REMOVE, '0);
    send_word(OP_REMOVE, '0);
    send_word(OP_REMOVE, '0);
    send_word(OP_QUERY, ALL_ONES);
    send_word(OP_QUERY, 31'h4000_0001);
    send_word(OP_REMOVE, 31'h7FFF_FFFE);
    send_word(OP_CLEAR, '0);
    send_word(OP_QUERY, 31'h1555_5555);
    send_word(OP_REMOVE, ALL_ONES);
    send_word(OP_INSERT, 31'h1555_5555);
    send_word(OP_INSERT, 31'h2AAA_AAAA);
    send_word(OP_QUERY, 31'h1555_5555);
    send_word(OP_REMOVE, 31'h2AAA_AAAA);
    send_word(OP_QUERY, 31'h1555_5555);
    send_word(OP_CLEAR, ALL_ONES);

    // burst of inserts: bit-reversed prefixes split early, so each insert
    // needs 20 or more new nodes
    send_idle_pct = 0;
    stall_pct = 0;
    fill_key = '0;
    for (int i = 0; i < FILL_WORDS; i++) begin
      idx = 11'(i);
      for (int b = 0; b < 11; b++) rev[b] = idx[10 - b];
      k = {rev, 20'($urandom())};
      if (i == 5) fill_key = k;
      send_word(OP_INSERT, k);
    end
    send_word(OP_INSERT, fill_key);
    send_word(OP_INSERT, fill_key ^ ONE);
    send_word(OP_INSERT, KEY_BITS'($urandom()));
    send_word(OP_QUERY, ~fill_key);
    send_word(OP_QUERY, KEY_BITS'($urandom()));
    send_word(OP_REMOVE, fill_key);
    send_word(OP_REMOVE, fill_key ^ ONE);
    send_word(OP_QUERY, fill_key);
    send_word(OP_CLEAR, '0);
    send_word(OP_INSERT, fill_key);
    send_word(OP_QUERY, '0);

    // random phases; the first one starts with a long output hold-off
    hold_req = 1'b1;
    run_random_phase(115, 0, 0);
    run_random_phase(115, 76, 0);
    run_random_phase(115, 0, 76);
    run_random_phase(115, 34, 34);
    in_valid <= 1'b0;

    while (sb.expected_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d clear, %0d insert (%0d refused, pool full), %0d remove, %0d query words",
             sb.op_seen[OP_CLEAR], sb.op_seen[OP_INSERT], sb.refused,
             sb.op_seen[OP_REMOVE], sb.op_seen[OP_QUERY]);
    $display("%0d result words checked, %0d nonzero query answers, %0d mismatches",
             sb.checked, sb.nonzero_answers, sb.mismatches);
    failed = (sb.mismatches != 0) || (sb.expected_replies.size() != 0);
    if (!failed) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
